/* rtl/bcp_pkg.sv */
// Shared types, constants and a 32-bit saturation helper for the cascaded balance controller.
package bcp_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAL_P   = 3'd0,
        REG_BAL_D   = 3'd1,
        REG_SPD_P   = 3'd2,
        REG_SPD_I   = 3'd3,
        REG_STR_P   = 3'd4,
        REG_STR_D   = 3'd5,
        REG_TRIM    = 3'd6,
        REG_UNUSED  = 3'd7
    } cfg_idx_t;

    localparam int unsigned FILT_W = 20;
    localparam int unsigned INTEG_W = 16;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

/* rtl/bcp_serial_mul.sv */
// Shift-and-add signed multiplier, one multiplier bit per cycle.
module bcp_serial_mul
    import bcp_pkg::*;
#(
    parameter int unsigned A_W = 48,
    parameter int unsigned B_W = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic                       done,
    output logic signed [A_W+B_W-1:0]  product
);
    localparam int unsigned P_W = A_W + B_W;
    localparam int unsigned CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [P_W-1:0]   acc_reg, acc_next;
    logic signed [P_W-1:0]   mcand_reg, mcand_next;
    logic [B_W-1:0]          mplier_reg, mplier_next;

    always_comb
    begin
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = P_W'(a);
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            // top bit of b carries negative weight
            if (mplier_reg[0])
            begin
                if (cnt_reg == CNT_W'(B_W - 1))
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

/* rtl/balance_cascade_pid_step.sv */
// Cascaded speed-PI / balance-PD / turn-PD step for a two-wheel balancer.
// Datapath: a bit-serial divide by ten, then six products through one
//   bit-serial multiplier, with sequencing states in between.
// One request is in flight at a time; the next request is accepted in
//   the cycle the result appears. Result register holds until taken.
// Reset (rst_n low, async): gains, trim, filter and integral state cleared.
module balance_cascade_pid_step
    import bcp_pkg::*;
#(
    parameter int signed INTEGRAL_LIMIT = 20000
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_count,
    input  logic signed [15:0] right_count,
    input  logic signed [15:0] tilt_angle,
    input  logic signed [15:0] tilt_rate,
    input  logic signed [15:0] yaw_rate,
    input  logic signed [15:0] speed_target,
    input  logic signed [15:0] turn_target,
    input  logic               stop_request,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] left_drive,
    output logic signed [31:0] right_drive,
    output logic signed [31:0] speed_loop_out
);
    localparam int unsigned A_W = 48;
    localparam int unsigned P_W = A_W + 16;
    localparam int unsigned DIV_W = 24;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_INTEG, ST_MUL_SP, ST_MUL_SI, ST_SPD,
        ST_MUL_BP, ST_MUL_BD, ST_MUL_TP, ST_MUL_TD, ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [15:0] bal_p_reg, bal_d_reg, spd_p_reg, spd_i_reg;
    logic signed [15:0] str_p_reg, str_d_reg, trim_reg;

    logic signed [FILT_W-1:0]  filt_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // latched request
    logic signed [15:0] tilt_reg, trate_reg, yrate_reg, ttarget_reg;
    logic               stop_reg;

    // divider: magnitude shift register, one quotient bit per cycle
    logic [DIV_W-1:0]   rem_reg, dvd_reg;
    logic               neg_reg;
    logic [4:0]         dcnt_reg;

    logic signed [P_W-1:0] acc_reg;
    logic signed [31:0]    spd_out_reg, vert_reg;

    logic                  res_valid_reg;
    logic signed [31:0]    left_reg, right_reg, speed_reg;

    // multiplier
    logic                  mul_start;
    logic signed [A_W-1:0] mul_a;
    logic signed [15:0]    mul_b;
    logic                  mul_done;
    logic signed [P_W-1:0] mul_p;

    bcp_serial_mul #(.A_W(A_W), .B_W(16)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign cfg_ready = 1'b1;
    // the result register parts the two sides: compute the next request while
    // a result waits, and hold it in the last step until the register frees
    assign in_ready  = (state_reg == ST_IDLE);

    // combinational helpers
    logic signed [17:0] err;
    logic signed [23:0] num;
    logic [DIV_W-1:0]   rem_shift;
    logic signed [FILT_W-1:0] filt_new;
    logic signed [FILT_W:0] isum;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [INTEG_W-1:0] integ_upd;
    logic signed [P_W-1:0] sp_sum, sp_q, bal_sum, bal_q, t_sum, t_q;
    logic signed [P_W-1:0] lsum, rsum;
    logic signed [A_W-1:0] diff;

    always_comb
    begin
        err = 18'(left_count) + 18'(right_count) - 18'(speed_target);
        num = 24'(err) * 24'sd3 + 24'(filt_reg) * 24'sd7;
        rem_shift = {rem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
        filt_new = neg_reg ? -FILT_W'(dvd_reg) : FILT_W'(dvd_reg);
        isum = (FILT_W+1)'(integ_reg) + (FILT_W+1)'(filt_reg);
        if (isum > (FILT_W+1)'(INTEGRAL_LIMIT))
            integ_new = INTEG_W'(INTEGRAL_LIMIT);
        else if (isum < -(FILT_W+1)'(INTEGRAL_LIMIT))
            integ_new = -INTEG_W'(INTEGRAL_LIMIT);
        else
            integ_new = isum[INTEG_W-1:0];
        // stop drops the integral after the clamp
        integ_upd = stop_reg ? '0 : integ_new;
        sp_sum = acc_reg + mul_p;
        // truncate toward zero: bias negatives before shifting
        sp_q  = (sp_sum + (sp_sum < 0 ? P_W'(255) : P_W'(0))) >>> 8;
        bal_sum = acc_reg + (mul_p <<< 7);
        bal_q = (bal_sum + (bal_sum < 0 ? P_W'(32767) : P_W'(0))) >>> 15;
        t_sum = acc_reg + mul_p;
        t_q   = (t_sum + (t_sum < 0 ? P_W'(255) : P_W'(0))) >>> 8;
        diff  = (A_W'(spd_out_reg) <<< 7) + A_W'(trim_reg) - A_W'(tilt_reg);
        lsum  = P_W'(vert_reg) - t_q;
        rsum  = P_W'(vert_reg) + t_q;
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_INTEG:  begin mul_start = 1'b1; mul_a = A_W'(filt_new); mul_b = spd_p_reg; end
            ST_MUL_SP: begin mul_start = mul_done; mul_a = A_W'(integ_upd);
                             mul_b = spd_i_reg; end
            ST_SPD:    begin mul_start = 1'b1; mul_a = diff; mul_b = bal_p_reg; end
            ST_MUL_BP: begin mul_start = mul_done; mul_a = A_W'(trate_reg);
                             mul_b = bal_d_reg; end
            ST_MUL_BD: begin mul_start = mul_done; mul_a = A_W'(ttarget_reg);
                             mul_b = str_p_reg; end
            ST_MUL_TP: begin mul_start = mul_done; mul_a = A_W'(yrate_reg);
                             mul_b = str_d_reg; end
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bal_p_reg <= '0; bal_d_reg <= '0; spd_p_reg <= '0; spd_i_reg <= '0;
            str_p_reg <= '0; str_d_reg <= '0; trim_reg <= '0;
            filt_reg  <= '0;
            integ_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_BAL_P:  bal_p_reg <= cfg_data;
                    REG_BAL_D:  bal_d_reg <= cfg_data;
                    REG_SPD_P:  spd_p_reg <= cfg_data;
                    REG_SPD_I:  spd_i_reg <= cfg_data;
                    REG_STR_P:  str_p_reg <= cfg_data;
                    REG_STR_D:  str_d_reg <= cfg_data;
                    REG_TRIM:   trim_reg  <= cfg_data;
                    REG_UNUSED: ;
                endcase
            end
            if (out_valid && out_ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        tilt_reg <= tilt_angle; trate_reg <= tilt_rate;
                        yrate_reg <= yaw_rate; ttarget_reg <= turn_target;
                        stop_reg <= stop_request;
                        neg_reg  <= num[23];
                        dvd_reg  <= num[23] ? DIV_W'(-num) : DIV_W'(num);
                        rem_reg  <= '0;
                        dcnt_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // restoring divide by ten, one quotient bit per cycle
                    if (rem_shift >= DIV_W'(10))
                    begin
                        rem_reg <= rem_shift - DIV_W'(10);
                        dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'(DIV_W - 1))
                        state_reg <= ST_INTEG;
                end
                ST_INTEG:
                begin
                    filt_reg <= filt_new;
                    state_reg <= ST_MUL_SP;
                end
                ST_MUL_SP:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_p;
                        integ_reg <= integ_upd;
                        state_reg <= ST_MUL_SI;
                    end
                end
                ST_MUL_SI:
                begin
                    if (mul_done)
                    begin
                        spd_out_reg <= sat32(sp_q);
                        state_reg <= ST_SPD;
                    end
                end
                ST_SPD:
                    state_reg <= ST_MUL_BP;
                ST_MUL_BP:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_p;
                        state_reg <= ST_MUL_BD;
                    end
                end
                ST_MUL_BD:
                begin
                    if (mul_done)
                    begin
                        vert_reg <= sat32(bal_q);
                        state_reg <= ST_MUL_TP;
                    end
                end
                ST_MUL_TP:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_p;
                        state_reg <= ST_MUL_TD;
                    end
                end
                ST_MUL_TD:
                begin
                    if (mul_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!res_valid_reg)
                    begin
                        left_reg  <= sat32(lsum);
                        right_reg <= sat32(rsum);
                        speed_reg <= spd_out_reg;
                        res_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid      = res_valid_reg;
    assign left_drive     = left_reg;
    assign right_drive    = right_reg;
    assign speed_loop_out = speed_reg;

`ifndef ASSERT_OFF
    // accept only when idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (state_reg == ST_IDLE)) else $error("accept busy");
    // integral stays within limits
    a_integ_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_W'(INTEGRAL_LIMIT)) && (integ_reg >= -INTEG_W'(INTEGRAL_LIMIT)))
        else $error("integral out of range");
    // stop clears integral
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_SP && mul_done && stop_reg) |=> (integ_reg == '0))
        else $error("stop not honored");
`endif
endmodule

/* tb/sv/tb_balance_cascade_pid_step.sv */
// Self-checking testbench for the cascaded balance PID step block.
module tb_balance_cascade_pid_step
    import bcp_pkg::*;
;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT = 20000;

    // One control request as seen at the input port.
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] tilt;
        logic signed [15:0] trate;
        logic signed [15:0] yrate;
        logic signed [15:0] spd_tgt;
        logic signed [15:0] turn_tgt;
        logic               stop;
    } tick_t;

    // One set of drive outputs.
    typedef struct {
        logic signed [31:0] left_drv;
        logic signed [31:0] right_drv;
        logic signed [31:0] spd_out;
    } drive_t;

    // Tracks gains, loop state and the queue of expected drive outputs.
    class drive_scoreboard;
        logic signed [15:0] gains [0:6];
        longint             filt_err;
        longint             integ;
        drive_t             pending_drives [$];
        int                 errors;

        function new();
            foreach (gains[i]) gains[i] = '0;
            filt_err = 0;
            integ = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            if (idx != REG_UNUSED)
                gains[idx] = val;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Advance the loop state by one tick and queue the drive it yields.
        function void note_tick(tick_t t);
            longint err, spd, diff, vert, turn;
            drive_t d;
            err = longint'(t.left) + longint'(t.right) - longint'(t.spd_tgt);
            filt_err = (3 * err + 7 * filt_err) / 10;
            integ = integ + filt_err;
            if (integ > LIMIT)
                integ = LIMIT;
            if (integ < -LIMIT)
                integ = -LIMIT;
            if (t.stop)
                integ = 0;
            spd = clamp32((longint'(gains[REG_SPD_P]) * filt_err
                           + longint'(gains[REG_SPD_I]) * integ) / 256);
            diff = spd * 128 + longint'(gains[REG_TRIM]) - longint'(t.tilt);
            vert = clamp32((longint'(gains[REG_BAL_P]) * diff
                            + longint'(gains[REG_BAL_D]) * longint'(t.trate) * 128)
                           / 32768);
            turn = (longint'(gains[REG_STR_P]) * longint'(t.turn_tgt)
                    + longint'(gains[REG_STR_D]) * longint'(t.yrate)) / 256;
            d.left_drv = clamp32(vert - turn);
            d.right_drv = clamp32(vert + turn);
            d.spd_out = spd;
            pending_drives.push_back(d);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_drive(drive_t got);
            drive_t exp_d;
            if (pending_drives.size() == 0)
            begin
                report("drive output with no request outstanding");
                return;
            end
            exp_d = pending_drives.pop_front();
            if (got.left_drv !== exp_d.left_drv)
                report($sformatf("left_drive got %0d want %0d", got.left_drv,
                                 exp_d.left_drv));
            if (got.right_drv !== exp_d.right_drv)
                report($sformatf("right_drive got %0d want %0d", got.right_drv,
                                 exp_d.right_drv));
            if (got.spd_out !== exp_d.spd_out)
                report($sformatf("speed_loop_out got %0d want %0d", got.spd_out,
                                 exp_d.spd_out));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] tilt_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] speed_target;
    logic signed [15:0] turn_target;
    logic               stop_request;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] left_drive;
    logic signed [31:0] right_drive;
    logic signed [31:0] speed_loop_out;

    drive_scoreboard sb;
    int              tx_idle_pct;
    int              rx_stall_pct;
    bit              hold_off;
    int              cycles;
    event            start_hold;

    balance_cascade_pid_step dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_count     (left_count),
        .right_count    (right_count),
        .tilt_angle     (tilt_angle),
        .tilt_rate      (tilt_rate),
        .yaw_rate       (yaw_rate),
        .speed_target   (speed_target),
        .turn_target    (turn_target),
        .stop_request   (stop_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_drive     (left_drive),
        .right_drive    (right_drive),
        .speed_loop_out (speed_loop_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Bound the run; a hung handshake ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    always
    begin
        @(start_hold);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Drive the receiver side on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
    end

    // Check every drive output that is taken.
    always @(posedge clk)
    begin
        drive_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.left_drv = left_drive;
            got.right_drv = right_drive;
            got.spd_out = speed_loop_out;
            sb.check_drive(got);
        end
    end

    // Write one register; only called while the block is idle.
    task write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task write_gains(logic [15:0] bp, logic [15:0] bd, logic [15:0] sp,
                     logic [15:0] si, logic [15:0] tp, logic [15:0] td,
                     logic [15:0] trim);
        write_reg(REG_BAL_P, bp);
        write_reg(REG_BAL_D, bd);
        write_reg(REG_SPD_P, sp);
        write_reg(REG_SPD_I, si);
        write_reg(REG_STR_P, tp);
        write_reg(REG_STR_D, td);
        write_reg(REG_TRIM, trim);
        // Unused index must leave everything alone.
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Offer one request, hold it until taken, then idle at random.
    task send_tick(tick_t t);
        @(negedge clk);
        in_valid <= 1'b1;
        left_count <= t.left;
        right_count <= t.right;
        tilt_angle <= t.tilt;
        tilt_rate <= t.trate;
        yaw_rate <= t.yrate;
        speed_target <= t.spd_tgt;
        turn_target <= t.turn_tgt;
        stop_request <= t.stop;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(t);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while ($urandom_range(99) < tx_idle_pct)
                @(negedge clk);
        end
    endtask

    // Drop valid, then wait until every request has produced its drive output.
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_drives.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly plausible encoder traffic so the filter and integral swing both ways.
    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(3) == 0)
        begin
            t.left = pick16();
            t.right = pick16();
            t.spd_tgt = pick16();
        end
        else
        begin
            t.left = 16'($signed($urandom_range(4000)) - 2000);
            t.right = 16'($signed($urandom_range(4000)) - 2000);
            t.spd_tgt = 16'($signed($urandom_range(2000)) - 1000);
        end
        t.tilt = ($urandom_range(4) == 0) ? pick16()
                                          : 16'($signed($urandom_range(46080)) - 23040);
        t.trate = pick16();
        t.yrate = pick16();
        t.turn_tgt = pick16();
        t.stop = ($urandom_range(9) == 0);
        return t;
    endfunction

    function automatic tick_t make_tick(logic [15:0] l, logic [15:0] r,
                                        logic [15:0] a, logic [15:0] g,
                                        logic [15:0] y, logic [15:0] s,
                                        logic [15:0] tt, logic st);
        tick_t t;
        t.left = l;
        t.right = r;
        t.tilt = a;
        t.trate = g;
        t.yrate = y;
        t.spd_tgt = s;
        t.turn_tgt = tt;
        t.stop = st;
        return t;
    endfunction

    task random_phase(int n);
        repeat (n) send_tick(random_tick());
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        hold_off = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {left_count, right_count, tilt_angle, tilt_rate} = '0;
        {yaw_rate, speed_target, turn_target} = '0;
        stop_request = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Gains at reset are zero: outputs must stay zero.
        send_tick(make_tick(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0));
        drain();

        // Directed: extreme gains with extreme inputs to hit every saturation.
        write_gains(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                    16'sh7fff, 16'sd23040);
        send_tick(make_tick(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0));
        send_tick(make_tick(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0));
        send_tick(make_tick(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh8000, 16'sh7fff, 16'sh8000, 1'b0));
        // Stop request clears the integral right after the clamp.
        send_tick(make_tick(16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0,
                            16'sh0, 16'sh0, 16'sh0, 1'b1));
        send_tick(make_tick(16'sh0, 16'sh0, 16'sh7fff, 16'sh0,
                            16'sh8000, 16'sh0, 16'sh7fff, 1'b0));
        drain();
        write_gains(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, -16'sd23040);
        send_tick(make_tick(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0));
        send_tick(make_tick(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh8000, 16'sh7fff, 16'sh8000, 1'b1));
        send_tick(make_tick(16'sh0, 16'sh0, 16'sh0, 16'sh0,
                            16'sh0, 16'sh0, 16'sh0, 1'b0));
        drain();
        // Trim beyond the nominal angle range is used as is.
        write_gains(16'sd256, 16'sd128, 16'sd512, 16'sd64, 16'sd300,
                    -16'sd200, 16'sh7fff);
        send_tick(make_tick(16'sd100, 16'sd90, 16'sh8000, 16'sd5,
                            -16'sd7, 16'sd50, 16'sd20, 1'b0));
        send_tick(make_tick(-16'sd100, -16'sd90, 16'sh7fff, -16'sd5,
                            16'sd7, -16'sd50, -16'sd20, 1'b0));
        drain();
        write_reg(REG_TRIM, 16'sh8000);
        send_tick(make_tick(16'sd1, -16'sd1, 16'sd23040, 16'sd0,
                            16'sd0, 16'sd3, 16'sd0, 1'b0));
        send_tick(make_tick(-16'sd3, 16'sd2, -16'sd23040, 16'sd1,
                            -16'sd1, 16'sd0, 16'sd1, 1'b1));
        drain();

        // Random phases: each idling mode under a different gain set.
        write_gains(16'sd256, 16'sd40, 16'sd128, 16'sd8, 16'sd256, -16'sd64, 16'sd0);
        random_phase(200);
        drain();

        tx_idle_pct = 59;
        write_gains(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                    16'($signed($urandom_range(46080)) - 23040));
        random_phase(200);
        drain();

        tx_idle_pct = 0;
        rx_stall_pct = 59;
        write_gains(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                    16'sh7fff, -16'sd23040);
        random_phase(200);
        drain();

        tx_idle_pct = 12;
        rx_stall_pct = 12;
        write_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(200);
        drain();

        // Hold the receiver off while requests keep coming so the block backs up.
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        write_gains(16'sd512, -16'sd256, 16'sd1000, 16'sd30, 16'sd100,
                    16'sd100, 16'sd23040);
        -> start_hold;
        random_phase(40);
        drain();

        tx_idle_pct = 59;
        rx_stall_pct = 59;
        write_gains(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                    pick16());
        random_phase(200);
        drain();

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        write_gains(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        random_phase(100);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            tx_idle_pct = (p == 1 || p == 3) ? 59 : 0;
            rx_stall_pct = (p >= 2) ? 59 : 12;
            write_gains(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                        pick16());
            random_phase(110);
            drain();
        end

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
